[rtl/fspa_pkg.sv]
`timescale 1ns / 1ps
// fspa_pkg: field widths, request modes and status codes of the slot pool allocator
package fspa_pkg;

  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // request modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // result status codes
  localparam status_t ST_OK            = 2'd0;
  localparam status_t ST_EMPTY         = 2'd1;
  localparam status_t ST_NOT_ALLOCATED = 2'd2;

endpackage

[rtl/fspa_if.sv]
`timescale 1ns / 1ps
// fspa_if: valid/ready channels for allocator requests and results
interface fspa_req_if;
  import fspa_pkg::*;

  logic  valid;
  logic  ready;
  logic  mode;
  slot_t slot;

  modport source (output valid, output mode, output slot, input ready);
  modport sink   (input valid, input mode, input slot, output ready);
endinterface

interface fspa_rsp_if;
  import fspa_pkg::*;

  logic    valid;
  logic    ready;
  slot_t   granted_slot;
  status_t status;
  count_t  free_count;

  modport source (output valid, output granted_slot, output status, output free_count,
                  input ready);
  modport sink   (input valid, input granted_slot, input status, input free_count,
                  output ready);
endinterface

[rtl/fixed_slot_pool_allocator.sv]
`timescale 1ns / 1ps
// fixed_slot_pool_allocator: lifo free-list allocator over a pool of equal slots
// request read at accept, then the update step loads the result word once no older word waits
// a new request waits until the last one is updated (read-then-write of the stack memory)
// a result word may wait at the output while the next request is accepted and read
// reset: synchronous active-low, depth and low-water mark go to SLOTS at once,
// no clearing pass; memory contents are never cleared
module fixed_slot_pool_allocator #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  fspa_req_if.sink    in_req,
  fspa_rsp_if.source  out_rsp
);
  import fspa_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW = $clog2(SLOTS + 1);
  localparam logic [DW-1:0] SLOTS_D = DW'(SLOTS);

  // sequencer codes
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // free stack and in-use bits, one entry per slot
  logic [AW-1:0] stack_mem [SLOTS];
  logic          use_mem   [SLOTS];

  // control state
  logic          state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  // low-water mark: entries below it were never popped or written, so they
  // still hold their reset value; slots at or above SLOTS - lw were never granted
  logic [DW-1:0] lw_r, lw_nxt;

  // captured request
  logic          mode_r;
  slot_t         slot_r;

  // memory ports
  logic          rd_en;
  logic [AW-1:0] stk_raddr, use_raddr;
  logic [AW-1:0] stk_rdata_r;
  logic          use_rdata_r;
  logic          stk_we, use_we, use_wdata;
  logic [AW-1:0] stk_waddr, stk_wdata, use_waddr;

  // result word register
  logic          out_valid_r, out_valid_nxt;
  slot_t         granted_r, granted_nxt;
  status_t       status_r, status_nxt;
  count_t        count_r, count_nxt;

  logic          in_acc;
  logic          exec_go;
  logic          fresh_top;
  logic [AW-1:0] got;
  logic          slot_in_range;
  logic          slot_used;

  assign in_acc  = in_req.valid && in_req.ready;
  // the update waits while an older result word has not been taken
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.granted_slot = granted_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.free_count   = count_r;

  // read addresses presented in the accept cycle
  assign rd_en     = in_acc;
  assign stk_raddr = AW'(depth_r - DW'(1));
  assign use_raddr = AW'(in_req.slot);

  // stack top either still at its reset value or taken from memory
  assign fresh_top     = (depth_r == lw_r);
  assign got           = fresh_top ? AW'(SLOTS_D - depth_r) : stk_rdata_r;
  assign slot_in_range = (32'(slot_r) < 32'(SLOTS));
  // slots never granted since reset read as free
  assign slot_used     = (32'(slot_r) < 32'(SLOTS_D - lw_r)) ? use_rdata_r : 1'b0;

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    lw_nxt        = lw_r;
    out_valid_nxt = out_valid_r;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    stk_we        = 1'b0;
    stk_waddr     = AW'(depth_r);
    stk_wdata     = AW'(slot_r);
    use_we        = 1'b0;
    use_waddr     = got;
    use_wdata     = 1'b1;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      state_nxt = S_EXEC;
    end

    if (exec_go) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      granted_nxt   = '0;
      status_nxt    = ST_OK;
      unique case (mode_r)
        MODE_ALLOC: begin
          if (depth_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            granted_nxt = SLOT_W'(got);
            depth_nxt   = depth_r - DW'(1);
            use_we      = 1'b1;
            if (fresh_top) begin
              lw_nxt = lw_r - DW'(1);
            end
          end
        end
        MODE_RELEASE: begin
          if (!slot_in_range || !slot_used || depth_r >= SLOTS_D) begin
            status_nxt = ST_NOT_ALLOCATED;
          end else begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + DW'(1);
            use_we    = 1'b1;
            use_waddr = AW'(slot_r);
            use_wdata = 1'b0;
          end
        end
        default: status_nxt = ST_NOT_ALLOCATED;
      endcase
      count_nxt = COUNT_W'(depth_nxt);
    end
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (rd_en) begin
      stk_rdata_r <= stack_mem[stk_raddr];
    end
  end

  // in-use memory, registered read
  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
    if (rd_en) begin
      use_rdata_r <= use_mem[use_raddr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_req.mode;
      slot_r <= in_req.slot;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    granted_r <= granted_nxt;
    status_r  <= status_nxt;
    count_r   <= count_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= SLOTS_D;
      lw_r        <= SLOTS_D;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      lw_r        <= lw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // stack depth never goes past the pool size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= SLOTS_D)
    else $error("stack depth above pool size");

  // low-water mark never above the current depth
  a_lw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lw_r <= depth_r)
    else $error("low-water mark above stack depth");

  // an accepted request moves the sequencer to the update step
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted request not followed by update step");

  // a new result word only follows an update step
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result word without update step");

  // depth changes by at most one per update and only in the update step
  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r != $past(depth_r)) |-> $past(exec_go))
    else $error("stack depth changed outside an update");
`endif

endmodule
